// ===== sv/eti_pkg.sv =====
// Shared constants, mode codes and controller/datapath interface types.
package eti_pkg;

	localparam int WFRAC = 16;
	localparam int WW = WFRAC + 1;
	localparam int CNT_W = $clog2(WFRAC);

	localparam logic [WW-1:0] W_ONE = WW'(1) << WFRAC;
	localparam logic [WW-1:0] W_HALF = WW'(1) << (WFRAC - 1);

	localparam logic [2:0] MODE_LINEAR = 3'd0;
	localparam logic [2:0] MODE_OUT_QUAD = 3'd1;
	localparam logic [2:0] MODE_OUT_QUINT = 3'd2;
	localparam logic [2:0] MODE_IN_OUT_QUAD = 3'd3;
	localparam logic [2:0] MODE_IN_OUT_QUINT = 3'd4;

	localparam logic REG_EASING_MODE = 1'b0;
	localparam logic REG_DURATION = 1'b1;

	typedef struct packed {
		logic load;
		logic div_step;
		logic wset;
		logic mul_step;
		logic ease_fin;
		logic blend_mul;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mul_n;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/eti_ctrl.sv =====
// Sequencer for divide, easing multiplies, blend and result hand-off.
module eti_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  eti_pkg::sts_t  sts,
	output eti_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV = 3'd1;
	localparam logic [2:0] S_WSET = 3'd2;
	localparam logic [2:0] S_MUL = 3'd3;
	localparam logic [2:0] S_EASED = 3'd4;
	localparam logic [2:0] S_BMUL = 3'd5;
	localparam logic [2:0] S_BADD = 3'd6;

	logic [2:0] state_q;
	logic [eti_pkg::CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_DIV: cmd.div_step = 1'b1;
			S_WSET: cmd.wset = 1'b1;
			S_MUL: cmd.mul_step = 1'b1;
			S_EASED: cmd.ease_fin = 1'b1;
			S_BMUL: cmd.blend_mul = 1'b1;
			S_BADD: cmd.commit = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DIV;
						cnt_q <= eti_pkg::CNT_W'(eti_pkg::WFRAC - 1);
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_WSET;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_WSET: begin
					if (sts.mul_n == 3'd0) begin
						state_q <= S_EASED;
					end else begin
						state_q <= S_MUL;
						cnt_q <= eti_pkg::CNT_W'(sts.mul_n - 3'd1);
					end
				end
				S_MUL: begin
					if (cnt_q == '0) begin
						state_q <= S_EASED;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_EASED: state_q <= S_BMUL;
				S_BMUL: state_q <= S_BADD;
				S_BADD: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/eti_dp.sv =====
// Datapath: elapsed time, restoring divider, easing multiplier, blend and output register.
module eti_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  eti_pkg::cmd_t             cmd,
	output eti_pkg::sts_t             sts,
	input  logic [2:0]                easing_mode,
	input  logic [31:0]               duration,
	input  logic [31:0]               start_value,
	input  logic [31:0]               end_value,
	input  logic [31:0]               time_step,
	input  logic                      frame_end,
	input  logic                      restart,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [31:0]               blended_value,
	output logic [eti_pkg::WW-1:0]    eased_weight,
	output logic                      finished
);

	localparam int WW = eti_pkg::WW;
	localparam int WF = eti_pkg::WFRAC;

	logic [31:0] elapsed_q;
	logic [31:0] start_q;
	logic [31:0] end_q;
	logic [31:0] step_q;
	logic        fend_q;
	logic        full_q;
	logic [31:0] rem_q;
	logic [WF-1:0] quo_q;
	logic [WW-1:0] w_q;
	logic [WW-1:0] b_q;
	logic [WW-1:0] p_q;
	logic        direct_q;
	logic [WW-1:0] eased_q;
	logic signed [50:0] prod_q;
	logic        out_valid_q;
	logic [31:0] out_blended_q;
	logic [WW-1:0] out_weight_q;
	logic        out_fin_q;

	logic [31:0] elapsed_eff;
	logic [32:0] shifted;
	logic        ge;
	logic [32:0] rem_sub;
	logic [WW-1:0] w_raw;
	logic [WW-1:0] u_raw;
	logic        is_inout;
	logic        direct;
	logic [2*WW-1:0] mprod;
	logic [WW+3:0] sub;
	logic [WW-1:0] sub_c;
	logic [WW-1:0] eased;
	logic signed [32:0] diff;
	logic [32:0] tsum;
	logic [31:0] elapsed_new;
	logic [31:0] blended;

	assign elapsed_eff = restart ? 32'd0 : elapsed_q;

	assign shifted = {rem_q, 1'b0};
	assign ge = shifted >= {1'b0, duration};
	assign rem_sub = shifted - {1'b0, duration};

	assign w_raw = full_q ? eti_pkg::W_ONE : {1'b0, quo_q};
	assign u_raw = eti_pkg::W_ONE - w_raw;
	assign is_inout = (easing_mode == eti_pkg::MODE_IN_OUT_QUAD) ||
		(easing_mode == eti_pkg::MODE_IN_OUT_QUINT);
	assign direct = is_inout && (w_raw < eti_pkg::W_HALF);

	assign mprod = p_q * b_q;

	assign sub = (easing_mode == eti_pkg::MODE_IN_OUT_QUINT) ? {p_q, 4'b0000}
		: {4'b0000, p_q};
	assign sub_c = (sub > {4'b0000, eti_pkg::W_ONE}) ? eti_pkg::W_ONE : sub[WW-1:0];

	always_comb begin
		case (easing_mode)
			eti_pkg::MODE_OUT_QUAD, eti_pkg::MODE_OUT_QUINT,
			eti_pkg::MODE_IN_OUT_QUAD, eti_pkg::MODE_IN_OUT_QUINT:
				eased = direct_q ? sub_c : eti_pkg::W_ONE - sub_c;
			default: eased = w_q;
		endcase
	end

	assign diff = $signed({end_q[31], end_q}) - $signed({start_q[31], start_q});

	assign tsum = {1'b0, elapsed_q} + {1'b0, step_q};
	assign elapsed_new = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
	assign blended = start_q + prod_q[WF+31:WF];

	always_comb begin
		sts.out_free = !out_valid_q || out_ready;
		case (easing_mode)
			eti_pkg::MODE_OUT_QUAD, eti_pkg::MODE_IN_OUT_QUAD: sts.mul_n = 3'd1;
			eti_pkg::MODE_OUT_QUINT, eti_pkg::MODE_IN_OUT_QUINT: sts.mul_n = 3'd4;
			default: sts.mul_n = 3'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && restart) begin
				elapsed_q <= '0;
			end else if (cmd.commit && fend_q) begin
				elapsed_q <= elapsed_new;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= start_value;
			end_q <= end_value;
			step_q <= time_step;
			fend_q <= frame_end;
			full_q <= (duration == 32'd0) || (elapsed_eff >= duration);
			rem_q <= elapsed_eff;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[31:0] : shifted[31:0];
			quo_q <= {quo_q[WF-2:0], ge};
		end
		if (cmd.wset) begin
			w_q <= w_raw;
			direct_q <= direct;
			b_q <= direct ? w_raw : u_raw;
			p_q <= direct ? w_raw : u_raw;
		end
		if (cmd.mul_step) begin
			if (easing_mode == eti_pkg::MODE_IN_OUT_QUAD) begin
				p_q <= mprod[WF-1+WW-1:WF-1];
			end else begin
				p_q <= mprod[WF+WW-1:WF];
			end
		end
		if (cmd.ease_fin) begin
			eased_q <= eased;
		end
		if (cmd.blend_mul) begin
			prod_q <= diff * $signed({1'b0, eased_q});
		end
		if (cmd.commit) begin
			out_blended_q <= blended;
			out_weight_q <= eased_q;
			out_fin_q <= fend_q && (elapsed_new >= duration);
		end
	end

	assign out_valid = out_valid_q;
	assign blended_value = out_blended_q;
	assign eased_weight = out_weight_q;
	assign finished = out_fin_q;

endmodule

// ===== sv/eased_transition_interpolator.sv =====
// Each input item runs through the 16-step restoring divider, then n steps of the shared
// 17x17 easing multiplier, then the blend multiply; a new item is taken only once the
// last result is committed. n is 0 for linear, 1 for quadratic and 4 for quintic modes.
// The next item is taken while a result waits in the output register.
// Reset (arst_n low) clears elapsed time, easing_mode, duration and the output valid flag.
module eased_transition_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // start_value, end_value, time_step
	input  logic        s_axis_tlast,
	input  logic [0:0]  s_axis_tuser,   // restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // blended_value, eased_weight, zero pad
	output logic [0:0]  m_axis_tuser,   // finished
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0]  easing_mode_q;
	logic [31:0] duration_q;
	logic        reg_idx;
	eti_pkg::cmd_t cmd;
	eti_pkg::sts_t sts;
	logic [31:0] blended_value;
	logic [eti_pkg::WW-1:0] eased_weight;
	logic        finished;

	assign pready = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			easing_mode_q <= eti_pkg::MODE_LINEAR;
			duration_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				eti_pkg::REG_EASING_MODE: easing_mode_q <= pwdata[2:0];
				eti_pkg::REG_DURATION: duration_q <= pwdata;
				default: duration_q <= duration_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			eti_pkg::REG_EASING_MODE: prdata = {29'd0, easing_mode_q};
			eti_pkg::REG_DURATION: prdata = duration_q;
			default: prdata = '0;
		endcase
	end

	eti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	eti_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.easing_mode   (easing_mode_q),
		.duration      (duration_q),
		.start_value   (s_axis_tdata[31:0]),
		.end_value     (s_axis_tdata[63:32]),
		.time_step     (s_axis_tdata[95:64]),
		.frame_end     (s_axis_tlast),
		.restart       (s_axis_tuser[0]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.blended_value (blended_value),
		.eased_weight  (eased_weight),
		.finished      (finished)
	);

	assign m_axis_tdata = {7'd0, eased_weight, blended_value};
	assign m_axis_tuser = finished;

endmodule
